[src/kfd_pkg.sv]
package kfd_pkg;

  // Default frame buffer size in bytes.
  localparam int BUFFER_DEPTH = 64;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;

  // KISS special characters.
  localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
  localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
  localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
  localparam logic [BYTE_W-1:0] TFESC = 8'hDD;

  // Reset value of the payload limit register.
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 6'd63;

  // Number of commands held between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Commands from the classifier to the buffer controller.
  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_CLOSE = 2'd1,
    OP_OVFL  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] command_byte;
    logic [LEN_W-1:0]  payload_length;
    logic              has_data;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } res_t;

endpackage

[src/kfd_ifs.sv]
// Received byte channel.
interface kfd_in_if;
  logic                      valid;
  logic                      ready;
  logic [kfd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Result channel.
interface kfd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [kfd_pkg::BYTE_W-1:0] command_byte;
  logic [kfd_pkg::LEN_W-1:0]  payload_length;
  logic                      has_data;
  logic [kfd_pkg::BYTE_W-1:0] data_byte;
  logic                      last;

  modport source (output valid, output status, output command_byte, output payload_length,
                  output has_data, output data_byte, output last, input ready);
  modport sink (input valid, input status, input command_byte, input payload_length,
                input has_data, input data_byte, input last, output ready);
endinterface

// Configuration write channel.
interface kfd_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [kfd_pkg::LEN_W-1:0] max_payload;

  modport source (output valid, output max_payload, input ready);
  modport sink (input valid, input max_payload, output ready);
endinterface

[src/kfd_front.sv]
module kfd_front #(
  parameter int BUFFER_DEPTH = kfd_pkg::BUFFER_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [kfd_pkg::BYTE_W-1:0] in_byte,
  output logic                       in_ready,
  input  logic [kfd_pkg::LEN_W-1:0]  max_payload,
  output logic                       q_push,
  output kfd_pkg::cmd_t              q_cmd,
  input  logic                       q_ready
);

  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic                       inside_r, inside_nxt;
  logic                       esc_r, esc_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic                       accept;
  logic [kfd_pkg::LEN_W:0]    fill_m1;
  logic [kfd_pkg::LEN_W-1:0]  close_len;
  logic [kfd_pkg::BYTE_W-1:0] unesc_byte;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  // Payload length of a closing frame: buffered bytes less the command, capped.
  assign fill_m1   = (kfd_pkg::LEN_W + 1)'(fill_r) - 1'b1;
  assign close_len = (fill_m1 > {1'b0, max_payload}) ? max_payload
                                                      : fill_m1[kfd_pkg::LEN_W-1:0];

  // Undo the escape of a byte that follows FESC.
  always_comb begin
    unesc_byte = in_byte;
    if (esc_r && in_byte == kfd_pkg::TFEND) begin
      unesc_byte = kfd_pkg::FEND;
    end else if (esc_r && in_byte == kfd_pkg::TFESC) begin
      unesc_byte = kfd_pkg::FESC;
    end
  end

  // Classify each received byte into a buffer command.
  always_comb begin
    inside_nxt = inside_r;
    esc_nxt    = esc_r;
    fill_nxt   = fill_r;
    q_push     = 1'b0;
    q_cmd      = '{op: kfd_pkg::OP_STORE, data: unesc_byte, len: '0};
    if (accept) begin
      if (in_byte == kfd_pkg::FEND) begin
        if (inside_r && fill_r != '0) begin
          q_push    = 1'b1;
          q_cmd.op  = kfd_pkg::OP_CLOSE;
          q_cmd.len = close_len;
        end
        inside_nxt = 1'b1;
        esc_nxt    = 1'b0;
        fill_nxt   = '0;
      end else if (inside_r) begin
        if (!esc_r && in_byte == kfd_pkg::FESC) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          q_push  = 1'b1;
          if (fill_r < CW'(BUFFER_DEPTH)) begin
            fill_nxt = CW'(fill_r + 1'b1);
          end else begin
            q_cmd.op   = kfd_pkg::OP_OVFL;
            fill_nxt   = '0;
            inside_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Frame tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      esc_r    <= 1'b0;
      fill_r   <= '0;
    end else begin
      inside_r <= inside_nxt;
      esc_r    <= esc_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

[src/kfd_queue.sv]
module kfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kfd_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output kfd_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  localparam int DEPTH = kfd_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  kfd_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != NW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = NW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = NW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/kfd_back.sv]
module kfd_back #(
  parameter int BUFFER_DEPTH = kfd_pkg::BUFFER_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  kfd_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output kfd_pkg::res_t out_res
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMD  = 3'b010,
    ST_DATA = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [kfd_pkg::BYTE_W-1:0] mem [BUFFER_DEPTH];
  logic [kfd_pkg::BYTE_W-1:0] rd_data_r;
  logic [AW-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]              rd_addr;
  logic                       rd_en;
  logic                       wr_en;
  logic [kfd_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [kfd_pkg::LEN_W-1:0]  idx_r, idx_nxt;
  logic [kfd_pkg::BYTE_W-1:0] cmd_r, cmd_nxt;
  logic                       out_valid_r;
  kfd_pkg::res_t              res_r;
  kfd_pkg::res_t              res_load;
  logic                       load;
  logic                       out_free;

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer: executes buffer writes, frame readout and overflow reports.
  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    cmd_nxt    = cmd_r;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    load       = 1'b0;
    res_load   = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            kfd_pkg::OP_STORE: begin
              q_pop      = 1'b1;
              wr_en      = 1'b1;
              wr_ptr_nxt = AW'(wr_ptr_r + 1'b1);
            end
            kfd_pkg::OP_CLOSE: begin
              q_pop      = 1'b1;
              rd_en      = 1'b1;
              wr_ptr_nxt = '0;
              len_nxt    = q_cmd.len;
              state_nxt  = ST_CMD;
            end
            kfd_pkg::OP_OVFL: begin
              if (out_free) begin
                q_pop           = 1'b1;
                wr_ptr_nxt      = '0;
                load            = 1'b1;
                res_load.status = 1'b1;
                res_load.last   = 1'b1;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_CMD: begin
        // The command byte from address zero is on the read port now.
        cmd_nxt = rd_data_r;
        if (len_r == '0) begin
          if (out_free) begin
            load                  = 1'b1;
            res_load.command_byte = rd_data_r;
            res_load.last         = 1'b1;
            state_nxt             = ST_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(1);
          idx_nxt   = kfd_pkg::LEN_W'(1);
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        // One payload byte per cycle while the output register drains.
        if (out_free) begin
          load                    = 1'b1;
          res_load.command_byte   = cmd_r;
          res_load.payload_length = len_r;
          res_load.has_data       = 1'b1;
          res_load.data_byte      = rd_data_r;
          res_load.last           = (idx_r == len_r);
          if (idx_r == len_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = kfd_pkg::LEN_W'(idx_r + 1'b1);
            rd_en   = 1'b1;
            rd_addr = idx_nxt[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Readout context and output payload.
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    idx_r <= idx_nxt;
    cmd_r <= cmd_nxt;
    if (load) begin
      res_r <= res_load;
    end
  end

  // Frame buffer with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= q_cmd.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[src/kiss_frame_decoder.sv]
// KISS receive deframer, store and forward.
// in_ch carries one received byte per transaction (in_byte). Bytes are
// unescaped and buffered; a FEND that closes a non-empty frame starts a run
// of results on out_ch: one per payload byte (or one with has_data low for
// an empty payload), each with the command byte and the truncated length,
// last set on the final one. A byte that overflows the buffer yields a single
// result with status high and drops the frame.
// cfg_ch writes max_payload (reset 63); it is always ready and is meant to
// be written while no frame is in flight.
// Flow: a byte is classified in the cycle it is accepted and queued. With an
// empty queue, the first result of a frame passes through the command queue,
// the ST_CMD and ST_DATA buffer reads (no ST_DATA read for an empty payload)
// and the output register; the run then delivers one result per cycle while
// out_ch is ready. An overflow report passes through the queue and the output
// register. The buffer has one read port, so while a frame is read out, in_ch
// accepts bytes only until the two-entry command queue fills.
// When out_ch stalls, the result is held in the output register and the
// readout pauses. Reset clears the frame state, the queue and the output
// valid; buffer contents are not cleared and need not be.
module kiss_frame_decoder #(
  parameter int BUFFER_DEPTH = kfd_pkg::BUFFER_DEPTH
) (
  input logic              clk,
  input logic              rst_n,
  kfd_in_if.sink           in_ch,
  kfd_out_if.source        out_ch,
  kfd_cfg_if.sink          cfg_ch
);

  logic [kfd_pkg::LEN_W-1:0] max_payload_r;
  logic                      push;
  logic                      push_ready;
  kfd_pkg::cmd_t             push_cmd;
  logic                      pop_valid;
  logic                      pop;
  kfd_pkg::cmd_t             pop_cmd;
  kfd_pkg::res_t             res;

  // Payload limit register.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= kfd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_ch.valid) begin
      max_payload_r <= cfg_ch.max_payload;
    end
  end

  // Byte classifier.
  kfd_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_byte    (in_ch.in_byte),
    .in_ready   (in_ch.ready),
    .max_payload(max_payload_r),
    .q_push     (push),
    .q_cmd      (push_cmd),
    .q_ready    (push_ready)
  );

  // Command queue between classifier and buffer controller.
  kfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop)
  );

  // Frame buffer and readout.
  kfd_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (pop_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (pop),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_res  (res)
  );

  assign out_ch.status         = res.status;
  assign out_ch.command_byte   = res.command_byte;
  assign out_ch.payload_length = res.payload_length;
  assign out_ch.has_data       = res.has_data;
  assign out_ch.data_byte      = res.data_byte;
  assign out_ch.last           = res.last;

endmodule

[src/kfd_checker.sv]
module kfd_checker (
  input logic       clk,
  input logic       rst_n,
  kfd_out_if.source out_ch
);

  // The result channel is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status) &&
      $stable(out_ch.command_byte) && $stable(out_ch.payload_length) &&
      $stable(out_ch.has_data) && $stable(out_ch.data_byte) && $stable(out_ch.last))
    else $error("stalled result changed");

  // An overflow report is a single result with all other fields zero.
  a_ovfl_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> out_ch.last && out_ch.command_byte == 8'd0 &&
      out_ch.payload_length == 6'd0 && !out_ch.has_data && out_ch.data_byte == 8'd0)
    else $error("malformed overflow result");

  // A frame result without data is the whole run of an empty payload.
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.status && !out_ch.has_data |->
      out_ch.last && out_ch.payload_length == 6'd0 && out_ch.data_byte == 8'd0)
    else $error("malformed empty frame result");

endmodule

bind kiss_frame_decoder kfd_checker u_kfd_checker (
  .clk   (clk),
  .rst_n (rst_n),
  .out_ch(out_ch)
);

[tb/sv/kiss_frame_decoder_checker.sv]
module kiss_frame_decoder_checker
  import kfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  kfd_in_if    in_ch,
  kfd_out_if   out_ch,
  kfd_cfg_if   cfg_ch,
  output int   mismatch_count,
  output int   results_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the deframer state.
  logic [BYTE_W-1:0] frame_bytes [0:BUFFER_DEPTH-1];
  logic [6:0]        fill;
  logic              frame_open;
  logic              esc_seen;
  logic [LEN_W-1:0]  payload_limit;

  // Results predicted but not yet seen on the output channel.
  res_t frame_results_q [$];

  function automatic res_t make_result(logic st, logic [BYTE_W-1:0] cmd,
                                       logic [LEN_W-1:0] len, logic hd,
                                       logic [BYTE_W-1:0] db, logic lst);
    res_t r;
    r.status         = st;
    r.command_byte   = cmd;
    r.payload_length = len;
    r.has_data       = hd;
    r.data_byte      = db;
    r.last           = lst;
    return r;
  endfunction

  // Buffer one unescaped byte, or report an overflow and drop the frame.
  task automatic store_byte(input logic [BYTE_W-1:0] b);
    if (fill < BUFFER_DEPTH) begin
      frame_bytes[fill[5:0]] = b;
      fill = fill + 7'd1;
    end else begin
      frame_results_q.push_back(make_result(1'b1, '0, '0, 1'b0, '0, 1'b1));
      fill       = '0;
      frame_open = 1'b0;
      esc_seen   = 1'b0;
    end
  endtask

  // Apply one received byte and queue the results it releases.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    logic [6:0] len;
    int         i;
    if (b == FEND) begin
      if (frame_open && fill != 0) begin
        len = fill - 7'd1;
        if (len > payload_limit) len = payload_limit;
        if (len == 0) begin
          frame_results_q.push_back(make_result(1'b0, frame_bytes[0], '0, 1'b0, '0, 1'b1));
        end else begin
          for (i = 0; i < len; i++) begin
            frame_results_q.push_back(make_result(1'b0, frame_bytes[0], len[LEN_W-1:0],
                                                  1'b1, frame_bytes[i+1], i == len - 1));
          end
        end
      end
      // Any FEND opens a fresh frame.
      frame_open = 1'b1;
      fill       = '0;
      esc_seen   = 1'b0;
    end else if (frame_open) begin
      if (esc_seen) begin
        esc_seen = 1'b0;
        if (b == TFEND) store_byte(FEND);
        else if (b == TFESC) store_byte(FESC);
        else store_byte(b);
      end else if (b == FESC) begin
        esc_seen = 1'b1;
      end else begin
        store_byte(b);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Observe all three channels at each rising edge.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      fill           = '0;
      frame_open     = 1'b0;
      esc_seen       = 1'b0;
      payload_limit  = MAX_PAYLOAD_RESET;
      mismatch_count = 0;
      frame_results_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status         = out_ch.status;
        got.command_byte   = out_ch.command_byte;
        got.payload_length = out_ch.payload_length;
        got.has_data       = out_ch.has_data;
        got.data_byte      = out_ch.data_byte;
        got.last           = out_ch.last;
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatch_count++;
        end else begin
          want = frame_results_q.pop_front();
          compare_field("status", 8'(want.status), 8'(got.status));
          compare_field("command_byte", want.command_byte, got.command_byte);
          compare_field("payload_length", 8'(want.payload_length), 8'(got.payload_length));
          compare_field("has_data", 8'(want.has_data), 8'(got.has_data));
          compare_field("data_byte", want.data_byte, got.data_byte);
          compare_field("last", 8'(want.last), 8'(got.last));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) payload_limit = cfg_ch.max_payload;
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.in_byte);
    end
    results_waiting <= frame_results_q.size();
  end

endmodule

[tb/sv/kiss_frame_decoder_tb.sv]
module kiss_frame_decoder_tb;
  import kfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS  = 12;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   results_waiting;
  int   bytes_sent;
  int   cycle_count;
  bit   no_stall;

  kfd_in_if  in_ch ();
  kfd_out_if out_ch ();
  kfd_cfg_if cfg_ch ();

  kiss_frame_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  kiss_frame_decoder_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side backpressure: ready is low with a probability of about 15 percent.
  always @(posedge clk) begin
    if (no_stall) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 15);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one byte, with valid occasionally held low first, and wait for the transaction.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!no_stall && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send a data byte with KISS escaping applied.
  task automatic send_escaped(input logic [BYTE_W-1:0] b);
    if (b == FEND) begin
      send_byte(FESC);
      send_byte(TFEND);
    end else if (b == FESC) begin
      send_byte(FESC);
      send_byte(TFESC);
    end else begin
      send_byte(b);
    end
  endtask

  // Payload content biased toward the special characters.
  function automatic logic [BYTE_W-1:0] payload_byte();
    if ($urandom_range(4) != 0) return BYTE_W'($urandom_range(255));
    case ($urandom_range(3))
      0: return FEND;
      1: return FESC;
      2: return TFEND;
      default: return TFESC;
    endcase
  endfunction

  // Stop offering bytes and let every predicted result drain out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [LEN_W-1:0] value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.max_payload <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well formed frames with random content, plus line noise.
  task automatic random_frames(input int count);
    int first;
    int pick;
    int len;
    int i;
    first = bytes_sent;
    while (bytes_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        if ($urandom_range(9) < 7) send_byte(FEND);
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(8);
        else if (pick < 93) len = $urandom_range(63, 9);
        else len = $urandom_range(66, 64);
        send_escaped(BYTE_W'($urandom_range(255)));
        for (i = 0; i < len; i++) send_escaped(payload_byte());
        send_byte(FEND);
      end else if (pick < 92) begin
        send_byte(BYTE_W'($urandom_range(255)));
      end else if (pick < 96) begin
        // Escape cut short by a delimiter.
        send_byte(FESC);
        send_byte(FEND);
      end else begin
        send_byte(FEND);
      end
    end
  endtask

  initial begin
    int i;
    no_stall           = 1'b0;
    bytes_sent         = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.in_byte      <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.max_payload <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_max_payload(6'd63);

    // Bytes outside a frame are dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Idle FEND, then an empty FEND.
    send_byte(FEND);
    send_byte(FEND);
    // Command byte only: one result without data.
    send_byte(8'h00);
    send_byte(FEND);
    // Every escape form, including an escaped ordinary byte.
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(FESC);
    send_byte(TFEND);
    send_byte(FESC);
    send_byte(TFESC);
    send_byte(FESC);
    send_byte(8'h41);
    send_byte(FEND);
    // A pending escape is dropped by the closing FEND.
    send_byte(8'h12);
    send_byte(FESC);
    send_byte(FEND);
    // Buffer overflow, then a byte that arrives outside any frame.
    for (i = 0; i < BUFFER_DEPTH + 1; i++) send_byte(BYTE_W'(8'h20 + i));
    send_byte(8'h55);
    send_byte(FEND);
    wait_idle();

    // Random traffic under several payload limits.
    write_max_payload(6'd0);
    random_frames(PHASE_ITEMS);
    wait_idle();

    write_max_payload(6'd1);
    random_frames(PHASE_ITEMS);
    wait_idle();

    // A long stretch with no idling on either side.
    no_stall = 1'b1;
    write_max_payload(6'd63);
    random_frames(3 * PHASE_ITEMS);
    wait_idle();
    no_stall = 1'b0;

    write_max_payload(LEN_W'($urandom_range(62, 2)));
    random_frames(PHASE_ITEMS);
    wait_idle();

    write_max_payload(6'd63);
    random_frames(PHASE_ITEMS);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
